@@ rtl/boolean_factor_local_search_core_assert.svh @@
// assertion macros for the boolean factor local search core
`ifndef BOOLEAN_FACTOR_LOCAL_SEARCH_CORE_ASSERT_SVH
`define BOOLEAN_FACTOR_LOCAL_SEARCH_CORE_ASSERT_SVH

// clocked check, off while reset is high
`define BFLS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define BFLS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bfls_pkg.sv @@
// shared constants and types of the boolean factor local search core
`timescale 1ns / 1ps
package bfls_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_RANK = 8;

  localparam int LANES  = 4;
  localparam int LANE_W = MAX_COLS / LANES;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int RANK_W    = $clog2(MAX_RANK);
  localparam int CNT_W     = $clog2(LANE_W + 1);
  localparam int ROW_ERR_W = $clog2(MAX_COLS + 1);
  localparam int ERR_W     = 13;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_FACT  = 2'd1;
  localparam logic [1:0] CMD_USAGE = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_RANK = 2'd2;

  typedef logic [LANE_W-1:0] slice_t;
  typedef slice_t [MAX_RANK-1:0] fslice_t;

  typedef struct packed {
    logic [CNT_W-1:0] ones;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] miss;
  } lane_cnt_t;

  typedef lane_cnt_t [LANES-1:0] lane_vec_t;

  typedef struct packed {
    logic                 set_bit;
    logic [ROW_ERR_W-1:0] row_err;
  } merge_t;

endpackage

@@ rtl/bfls_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bfls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/bfls_lane.sv @@
// one column lane: free column and mismatch counts over a slice
`timescale 1ns / 1ps
module bfls_lane (
  input  logic                      clk,
  input  bfls_pkg::fslice_t         fact,
  input  bfls_pkg::slice_t          data,
  input  bfls_pkg::slice_t          mask,
  input  logic [bfls_pkg::MAX_RANK-1:0] usage,
  input  logic [bfls_pkg::RANK_W-1:0]   sel,
  output bfls_pkg::lane_cnt_t       cnt
);
  import bfls_pkg::*;

  slice_t other;
  slice_t free_c;
  slice_t full;

  always_comb begin
    other = '0;
    for (int k = 0; k < MAX_RANK; k++) begin
      if (usage[k] && (k[RANK_W-1:0] != sel)) begin
        other = other | fact[k];
      end
    end
    free_c = fact[sel] & mask & ~other;
    full   = usage[sel] ? (other | fact[sel]) : other;
  end

  always_ff @(posedge clk) begin
    cnt.ones  <= CNT_W'($countones(free_c & data));
    cnt.zeros <= CNT_W'($countones(free_c & ~data));
    cnt.miss  <= CNT_W'($countones((full ^ data) & mask));
  end
endmodule

@@ rtl/bfls_merge.sv @@
// merges lane counts into the usage decision and the row error
`timescale 1ns / 1ps
module bfls_merge (
  input  bfls_pkg::lane_vec_t lanes,
  output bfls_pkg::merge_t    res
);
  import bfls_pkg::*;

  logic [ROW_ERR_W-1:0] ones_sum;
  logic [ROW_ERR_W-1:0] zeros_sum;
  logic [ROW_ERR_W-1:0] miss_sum;

  always_comb begin
    ones_sum  = '0;
    zeros_sum = '0;
    miss_sum  = '0;
    for (int g = 0; g < LANES; g++) begin
      ones_sum  = ones_sum  + ROW_ERR_W'(lanes[g].ones);
      zeros_sum = zeros_sum + ROW_ERR_W'(lanes[g].zeros);
      miss_sum  = miss_sum  + ROW_ERR_W'(lanes[g].miss);
    end
    res.set_bit = ones_sum > zeros_sum;
    res.row_err = miss_sum;
  end
endmodule

@@ rtl/boolean_factor_local_search_core.sv @@
// top level of the boolean factor local search core
// loads are taken only while idle; start evaluates, then sweeps until no gain
// the evaluation pass runs the column lanes then the merge once per row for its error
// in a sweep, each row step runs the column lanes then the merge once per factor, then once more for the row error
// results follow one row at a time, each held until out_ready is high
// synchronous reset: idle, least error zero, registers at their largest values
`timescale 1ns / 1ps
module boolean_factor_local_search_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [6:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [5:0]                  row_index,
  input  logic [63:0]                 row_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  out_row,
  output logic [7:0]                  usage_bits,
  output logic [bfls_pkg::ERR_W-1:0]  error_count,
  output logic                        last
);
  import bfls_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_WT    = 9'b000000100,
    S_LANE  = 9'b000001000,
    S_MRG   = 9'b000010000,
    S_ENDP  = 9'b000100000,
    S_ORD   = 9'b001000000,
    S_OWT   = 9'b010000000,
    S_OSEND = 9'b100000000
  } state_t;

  state_t state;

  logic [6:0] rows_in_use, cols_in_use;
  logic [3:0] rank_in_use;
  logic [6:0] rows, cols;
  logic [3:0] rank;
  logic [MAX_COLS-1:0] colmask;
  logic [MAX_RANK-1:0] rankmask;
  logic [MAX_ROWS-1:0] row_mask;

  logic [MAX_COLS-1:0] factors [MAX_RANK];
  logic [MAX_COLS-1:0] drow;
  logic [MAX_RANK-1:0] usage;
  logic [RANK_W-1:0]   l;
  logic [ROW_W-1:0]    row;
  logic                err_step, eval_pass;
  logic [MAX_ROWS-1:0] row_bank;
  logic [ERR_W-1:0]    err_acc, least_error;

  logic                in_xfer;
  logic [MAX_COLS-1:0] data_rdata;
  logic [MAX_RANK-1:0] u_rdata [2];
  logic [MAX_RANK-1:0] u_sel;
  logic                u_we [2];
  logic [ROW_W-1:0]    u_waddr;
  logic [MAX_RANK-1:0] u_wdata;
  logic                u_load;
  logic                row_wr;
  logic                wr_bank;

  fslice_t   fsl [LANES];
  lane_vec_t lane_cnt;
  merge_t    mres;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    rows = (rows_in_use == 7'd0) ? 7'd1 :
           (rows_in_use > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_in_use;
    cols = (cols_in_use == 7'd0) ? 7'd1 :
           (cols_in_use > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_in_use;
    rank = (rank_in_use == 4'd0) ? 4'd1 :
           (rank_in_use > 4'(MAX_RANK)) ? 4'(MAX_RANK) : rank_in_use;
    for (int j = 0; j < MAX_COLS; j++) begin
      colmask[j] = j < int'(cols);
    end
    for (int k = 0; k < MAX_RANK; k++) begin
      rankmask[k] = k < int'(rank);
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      row_mask[i] = i < int'(rows);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'(MAX_ROWS);
      cols_in_use <= 7'(MAX_COLS);
      rank_in_use <= 4'(MAX_RANK);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        REG_RANK: rank_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && command == CMD_FACT && int'(row_index) < MAX_RANK) begin
      factors[row_index[RANK_W-1:0]] <= row_bits;
    end
  end

  bfls_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_data_ram (
    .clk   (clk),
    .we    (in_xfer && command == CMD_DATA),
    .waddr (row_index),
    .wdata (row_bits),
    .raddr (row),
    .rdata (data_rdata)
  );

  // each row keeps its own bank select; the evaluation pass writes the masked
  // best row back in place, a sweep writes the trial row to the other bank
  assign u_load   = in_xfer && command == CMD_USAGE;
  assign row_wr   = (state == S_MRG) && err_step;
  assign wr_bank  = eval_pass ? row_bank[row] : !row_bank[row];
  assign u_waddr  = row_wr ? row : row_index;
  assign u_wdata  = row_wr ? usage : row_bits[MAX_RANK-1:0];
  assign u_we[0]  = u_load || (row_wr && !wr_bank);
  assign u_we[1]  = row_wr && wr_bank;
  assign u_sel    = row_bank[row] ? u_rdata[1] : u_rdata[0];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    bfls_ram #(.WIDTH(MAX_RANK), .DEPTH(MAX_ROWS)) u_usage_ram (
      .clk   (clk),
      .we    (u_we[b]),
      .waddr (u_waddr),
      .wdata (u_wdata),
      .raddr (row),
      .rdata (u_rdata[b])
    );
  end

  always_comb begin
    for (int g = 0; g < LANES; g++) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        fsl[g][k] = factors[k][g*LANE_W +: LANE_W];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bfls_lane u_lane (
      .clk   (clk),
      .fact  (fsl[g]),
      .data  (drow[g*LANE_W +: LANE_W]),
      .mask  (colmask[g*LANE_W +: LANE_W]),
      .usage (usage),
      .sel   (l),
      .cnt   (lane_cnt[g])
    );
  end

  bfls_merge u_merge (
    .lanes (lane_cnt),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      least_error <= '0;
      row_bank    <= '0;
      out_valid   <= 1'b0;
      row         <= '0;
      l           <= '0;
      err_step    <= 1'b0;
      eval_pass   <= 1'b0;
      err_acc     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (u_load) begin
            row_bank[row_index] <= 1'b0;
          end
          if (in_xfer && command == CMD_START) begin
            row       <= '0;
            err_acc   <= '0;
            eval_pass <= 1'b1;
            state     <= S_RD;
          end
        end
        S_RD: state <= S_WT;
        S_WT: begin
          drow     <= data_rdata;
          usage    <= u_sel & rankmask;
          l        <= '0;
          err_step <= eval_pass;
          state    <= S_LANE;
        end
        S_LANE: state <= S_MRG;
        S_MRG: begin
          if (!err_step) begin
            usage[l] <= mres.set_bit;
            if ({1'b0, l} + 4'd1 == rank) begin
              err_step <= 1'b1;
              l        <= '0;
            end else begin
              l <= l + 1'b1;
            end
            state <= S_LANE;
          end else begin
            err_acc <= err_acc + ERR_W'(mres.row_err);
            if ({1'b0, row} + 7'd1 == rows) begin
              state <= S_ENDP;
            end else begin
              row   <= row + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_ENDP: begin
          row     <= '0;
          err_acc <= '0;
          if (eval_pass) begin
            least_error <= err_acc;
            eval_pass   <= 1'b0;
            state       <= S_RD;
          end else if (err_acc < least_error) begin
            least_error <= err_acc;
            row_bank    <= row_bank ^ row_mask;
            state       <= S_RD;
          end else begin
            state <= S_ORD;
          end
        end
        S_ORD: state <= S_OWT;
        S_OWT: begin
          out_row     <= row;
          usage_bits  <= u_sel & rankmask;
          error_count <= least_error;
          last        <= ({1'b0, row} + 7'd1 == rows);
          out_valid   <= 1'b1;
          state       <= S_OSEND;
        end
        S_OSEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              row   <= row + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "boolean_factor_local_search_core_assert.svh"

  `BFLS_CHECK(a_excl, !(in_ready && out_valid), "input and output open together")
  `BFLS_CHECK(a_step, (state == S_MRG && !err_step) |-> ({1'b0, l} < rank), "factor step past rank")
  `BFLS_CHECK(a_flip, (state == S_ENDP && !eval_pass && err_acc < least_error) |=> (row_bank[0] != $past(row_bank[0])), "kept sweep did not swap banks")
  `BFLS_CHECK(a_oval, out_valid |-> (state == S_OSEND), "result shown outside send state")

endmodule
